@@ sv/sstf_request_selector_defines.svh @@
// ----------------------------------------------------------------------------
// sstf request selector assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef SSTF_REQUEST_SELECTOR_DEFINES_SVH
`define SSTF_REQUEST_SELECTOR_DEFINES_SVH

// condition that must hold at every clock edge
`define SSR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sstf request selector: invariant violated");

// consequent must hold in the same cycle as the antecedent
`define SSR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sstf request selector: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sstf request selector: next-cycle check failed");

`endif

@@ sv/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// shared constants, codes and types of the sstf request selector
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int LBA_BITS    = 48;
   localparam int TAG_BITS    = 8;
   localparam int DEV_BITS    = 3;

   localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
   localparam int RANK_BITS   = SLOT_BITS;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   // reads go out for every slot, then the scan waits while the last
   // read passes the ram latency and the two compare stages
   localparam int SCAN_LAST   = QUEUE_DEPTH + 2;
   localparam int SCAN_BITS   = $clog2(SCAN_LAST + 1);
   localparam int ENTRY_BITS  = LBA_BITS + TAG_BITS + DEV_BITS;

   // opcodes
   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // response status codes
   localparam logic [1:0] ST_INSERTED   = 2'd0;
   localparam logic [1:0] ST_DISPATCHED = 2'd1;
   localparam logic [1:0] ST_EMPTY      = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   typedef struct packed {
      logic [LBA_BITS-1:0] lba;
      logic [TAG_BITS-1:0] tag;
      logic [DEV_BITS-1:0] dev;
   } entry_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] idx;
      logic [RANK_BITS-1:0] rank;
      entry_type            entry;
   } best_type;

endpackage

@@ sv/ssr_ram.sv @@
// ----------------------------------------------------------------------------
// ssr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ssr_scan.sv @@
// ----------------------------------------------------------------------------
// ssr_scan
// two-stage seek distance compare, keeps the nearest entry seen so far
// ----------------------------------------------------------------------------
module ssr_scan
   import ssr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 in_valid,
   input  logic [SLOT_BITS-1:0] in_idx,
   input  logic [RANK_BITS-1:0] in_rank,
   input  entry_type            in_entry,
   input  logic [LBA_BITS-1:0]  head,
   output best_type             best
);

   // stage a: absolute distance to the head
   logic                 a_valid_ff, a_valid_in;
   logic [SLOT_BITS-1:0] a_idx_ff;
   logic [RANK_BITS-1:0] a_rank_ff;
   entry_type            a_entry_ff;
   logic [LBA_BITS-1:0]  a_gap_ff, a_gap_in;

   // stage b: running best
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] best_idx_ff, best_idx_in;
   logic [RANK_BITS-1:0] best_rank_ff, best_rank_in;
   entry_type            best_entry_ff, best_entry_in;
   logic [LBA_BITS-1:0]  best_gap_ff, best_gap_in;
   logic                 take;

   always_comb begin
      a_valid_in = in_valid && !clear;
      a_gap_in   = (head > in_entry.lba) ? (head - in_entry.lba) : (in_entry.lba - head);
   end

   // strictly nearer wins, equal distance goes to the older arrival
   always_comb begin
      take = a_valid_ff && (!found_ff || (a_gap_ff < best_gap_ff) ||
             ((a_gap_ff == best_gap_ff) && (a_rank_ff < best_rank_ff)));
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_rank_in  = best_rank_ff;
      best_entry_in = best_entry_ff;
      best_gap_in   = best_gap_ff;
      priority if (clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in      = 1'b1;
         best_idx_in   = a_idx_ff;
         best_rank_in  = a_rank_ff;
         best_entry_in = a_entry_ff;
         best_gap_in   = a_gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         found_ff   <= found_in;
      end
      a_idx_ff      <= in_idx;
      a_rank_ff     <= in_rank;
      a_entry_ff    <= in_entry;
      a_gap_ff      <= a_gap_in;
      best_idx_ff   <= best_idx_in;
      best_rank_ff  <= best_rank_in;
      best_entry_ff <= best_entry_in;
      best_gap_ff   <= best_gap_in;
   end

   always_comb begin
      best.found = found_ff;
      best.idx   = best_idx_ff;
      best.rank  = best_rank_ff;
      best.entry = best_entry_ff;
   end

endmodule

@@ sv/sstf_request_selector.sv @@
// ----------------------------------------------------------------------------
// sstf_request_selector
// shortest-seek-time-first pick over a table of pending block requests
// ----------------------------------------------------------------------------
// usage
//  - a transaction is taken at a rising edge with start high and busy low;
//    req_opcode selects insert (req_lba, req_tag, req_device) or dispatch
//  - every transaction gives exactly one response: rsp_valid is high for one
//    cycle with rsp_status and, for a dispatch, the removed request's fields
//  - insert: response in the cycle after acceptance, busy stays low, so
//    inserts go at one per cycle; a full table answers with the full status
//  - dispatch on an empty table: response next cycle, busy stays low
//  - dispatch otherwise: busy while the entry ram is read one slot per
//    cycle by a single distance comparator and the last read drains
//    through the ram and two compare stages, then the response is registered
//  - the receiver cannot stall; a new transaction may be accepted in the
//    cycle its predecessor's response is shown
//  - reset clears the valid bits, entry count and head position at once;
//    there is no clearing pass over the entry ram
//  - the ram is never written while a scan reads it: busy is the interlock
// ----------------------------------------------------------------------------
`include "sstf_request_selector_defines.svh"

module sstf_request_selector
   import ssr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [LBA_BITS-1:0] req_lba,
   input  logic [TAG_BITS-1:0] req_tag,
   input  logic [DEV_BITS-1:0] req_device,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic [LBA_BITS-1:0] rsp_out_lba,
   output logic [DEV_BITS-1:0] rsp_out_device
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   // control state
   logic                   state_ff, state_in;
   logic [SCAN_BITS-1:0]   scan_cnt_ff, scan_cnt_in;
   logic                   rd_issue_ff, rd_issue_in;
   logic [SLOT_BITS-1:0]   rd_idx_ff;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [LBA_BITS-1:0]    head_ff, head_in;

   // arrival ranks, one per slot, only meaningful where the slot is valid
   logic [RANK_BITS-1:0]   rank_ff [QUEUE_DEPTH];
   logic [RANK_BITS-1:0]   rank_in [QUEUE_DEPTH];

   // response registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   entry_type              rsp_entry_ff, rsp_entry_in;

   logic                   accept;
   logic                   do_insert;
   logic                   do_dispatch;
   logic                   table_full;
   logic                   table_empty;
   logic                   scan_done;
   logic                   rd_en;
   logic [SLOT_BITS-1:0]   free_slot;
   entry_type              wr_entry;
   entry_type              rd_entry;
   logic [ENTRY_BITS-1:0]  rd_data;
   best_type               best;

   assign busy        = (state_ff == S_SCAN);
   assign accept      = start && !busy;
   assign table_full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign table_empty = (count_ff == '0);
   assign do_insert   = accept && (req_opcode == OP_INSERT) && !table_full;
   assign do_dispatch = accept && (req_opcode == OP_DISPATCH) && !table_empty;
   assign scan_done   = busy && (scan_cnt_ff == SCAN_BITS'(SCAN_LAST));
   assign rd_en       = busy && (scan_cnt_ff < SCAN_BITS'(QUEUE_DEPTH));

   // lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      wr_entry.lba = req_lba;
      wr_entry.tag = req_tag;
      wr_entry.dev = req_device;
   end

   // entry payload store
   ssr_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (do_insert),
      .wr_addr (free_slot),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_cnt_ff[SLOT_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;

   // distance compare, fed one slot per cycle behind the ram read
   ssr_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .clear    (do_dispatch),
      .in_valid (rd_issue_ff && valid_ff[rd_idx_ff]),
      .in_idx   (rd_idx_ff),
      .in_rank  (rank_ff[rd_idx_ff]),
      .in_entry (rd_entry),
      .head     (head_ff),
      .best     (best)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      rd_issue_in = rd_en;
      unique case (state_ff)
         S_IDLE: begin
            scan_cnt_in = '0;
            if (do_dispatch) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_IDLE;
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // table bookkeeping: valid bits, count, ranks, head
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      head_in  = head_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         rank_in[i] = rank_ff[i];
      end
      priority if (do_insert) begin
         valid_in[free_slot] = 1'b1;
         rank_in[free_slot]  = count_ff[RANK_BITS-1:0];
         count_in            = count_ff + 1'b1;
      end else if (scan_done) begin
         // close the rank gap left by the removed entry
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (valid_ff[i] && (rank_ff[i] > best.rank)) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
         valid_in[best.idx] = 1'b0;
         count_in           = count_ff - 1'b1;
         head_in            = best.entry.lba;
      end
   end

   // response
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_INSERTED;
      rsp_entry_in  = '0;
      priority if (scan_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_DISPATCHED;
         rsp_entry_in  = best.entry;
      end else if (accept) begin
         rsp_valid_in = !do_dispatch;
         unique case (req_opcode)
            OP_INSERT:   rsp_status_in = table_full ? ST_FULL : ST_INSERTED;
            OP_DISPATCH: rsp_status_in = ST_EMPTY;
            default:     rsp_status_in = ST_EMPTY;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_cnt_ff  <= '0;
         rd_issue_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_issue_ff  <= rd_issue_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= scan_cnt_ff[SLOT_BITS-1:0];
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         rank_ff[i] <= rank_in[i];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_tag    = rsp_entry_ff.tag;
   assign rsp_out_lba    = rsp_entry_ff.lba;
   assign rsp_out_device = rsp_entry_ff.dev;

   // entry count tracks the valid bits
   `SSR_ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_ff) == count_ff)
   // a non-empty dispatch always finds an entry by the end of the scan
   `SSR_ASSERT_SAME(a_scan_finds_entry, scan_done, best.found && valid_ff[best.idx])
   // insert and empty-dispatch transactions answer on the next cycle
   `SSR_ASSERT_NEXT(a_quick_response, accept && !do_dispatch, rsp_valid && !busy)
   // a dispatch response moves the head to the returned address
   `SSR_ASSERT_SAME(a_head_follows, rsp_valid && (rsp_status == ST_DISPATCHED),
      head_ff == rsp_out_lba)

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sstf request selector: a directed table of
// transactions, then random insert/dispatch bursts, every response checked
// in order against typed expectations or an in-bench nearest-seek scheduler
// ----------------------------------------------------------------------------
module tb_top
   import ssr_pkg::*;
();

   localparam int                  HALF_PERIOD = 6;
   localparam int                  RANDOM_ITEMS = 1000;
   localparam int                  DRAIN_CYCLES = 40;      // dispatch busy window plus margin
   localparam logic [LBA_BITS-1:0] LBA_MAX = '1;

   // one response as it appears on the rsp_ ports
   typedef struct packed {
      logic [1:0]          status;
      logic [TAG_BITS-1:0] tag;
      logic [LBA_BITS-1:0] lba;
      logic [DEV_BITS-1:0] dev;
   } rsp_fields_type;

   localparam rsp_fields_type FROM_MODEL = '0;

   // one row of the directed table; reps > 1 walks lba, tag and device upward
   typedef struct packed {
      logic                op;
      logic [LBA_BITS-1:0] lba;
      logic [TAG_BITS-1:0] tag;
      logic [DEV_BITS-1:0] dev;
      logic [5:0]          reps;
      logic                known;
      rsp_fields_type      want;
   } cmd_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = OP_INSERT;
   logic [LBA_BITS-1:0] req_lba = '0;
   logic [TAG_BITS-1:0] req_tag = '0;
   logic [DEV_BITS-1:0] req_device = '0;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic [TAG_BITS-1:0] rsp_out_tag;
   logic [LBA_BITS-1:0] rsp_out_lba;
   logic [DEV_BITS-1:0] rsp_out_device;

   // typed expectation travelling with the transaction currently offered
   logic           typed_known = 1'b0;
   rsp_fields_type typed_rsp = '0;

   rsp_fields_type rsp_due_q[$];
   int             mismatch_count = 0;

   // scheduler state kept by the bench
   logic                tbl_valid [QUEUE_DEPTH];
   logic [LBA_BITS-1:0] tbl_lba   [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] tbl_tag   [QUEUE_DEPTH];
   logic [DEV_BITS-1:0] tbl_dev   [QUEUE_DEPTH];
   int                  tbl_rank  [QUEUE_DEPTH];
   logic [LBA_BITS-1:0] tbl_head = '0;
   int                  tbl_count = 0;

   // directed transactions: empty table, lba extremes both ways round,
   // same lba twice, ties above and below the head, full table, drain to empty
   cmd_row_type dir_rows [19] = '{
      '{OP_DISPATCH, '0, '0, '0, 6'd1, 1'b1, '{ST_EMPTY, '0, '0, '0}},
      '{OP_INSERT, LBA_MAX, 8'hff, 3'd7, 6'd1, 1'b1, '{ST_INSERTED, '0, '0, '0}},
      '{OP_DISPATCH, '0, '0, '0, 6'd1, 1'b1, '{ST_DISPATCHED, 8'hff, LBA_MAX, 3'd7}},
      '{OP_INSERT, '0, 8'h00, 3'd0, 6'd1, 1'b1, '{ST_INSERTED, '0, '0, '0}},
      '{OP_DISPATCH, LBA_MAX, 8'hff, 3'd7, 6'd1, 1'b1, '{ST_DISPATCHED, '0, '0, '0}},
      '{OP_INSERT, 48'd100, 8'd1, 3'd1, 6'd1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd100, 8'd2, 3'd2, 6'd1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd50, 8'd3, 3'd3, 6'd1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd0, 8'd4, 3'd4, 6'd1, 1'b0, FROM_MODEL},
      '{OP_DISPATCH, '0, '0, '0, 6'd4, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd300, 8'd5, 3'd5, 6'd1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd200, 8'd6, 3'd6, 6'd1, 1'b0, FROM_MODEL},
      '{OP_DISPATCH, '0, '0, '0, 6'd1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd100, 8'd7, 3'd7, 6'd1, 1'b0, FROM_MODEL},
      '{OP_DISPATCH, '0, '0, '0, 6'd2, 1'b0, FROM_MODEL},
      '{OP_INSERT, 48'd1000, 8'd16, 3'd0, 6'd32, 1'b0, FROM_MODEL},
      '{OP_INSERT, LBA_MAX, 8'haa, 3'd5, 6'd1, 1'b1, '{ST_FULL, '0, '0, '0}},
      '{OP_DISPATCH, '0, '0, '0, 6'd32, 1'b0, FROM_MODEL},
      '{OP_DISPATCH, '0, '0, '0, 6'd1, 1'b1, '{ST_EMPTY, '0, '0, '0}}
   };

   sstf_request_selector dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_lba        (req_lba),
      .req_tag        (req_tag),
      .req_device     (req_device),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_lba    (rsp_out_lba),
      .rsp_out_device (rsp_out_device)
   );

   always #HALF_PERIOD clock = ~clock;

   // advance the scheduler by one transaction and return its response
   function automatic rsp_fields_type apply_request(input logic op,
                                                    input logic [LBA_BITS-1:0] lba,
                                                    input logic [TAG_BITS-1:0] tag,
                                                    input logic [DEV_BITS-1:0] dev);
      rsp_fields_type      r;
      int                  slot;
      int                  pick;
      logic [LBA_BITS-1:0] seek_gap;
      logic [LBA_BITS-1:0] pick_dist;
      r = '0;
      if (op == OP_INSERT) begin
         // lowest free slot
         slot = -1;
         for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
         end
         if (tbl_count >= QUEUE_DEPTH || slot < 0) begin
            r.status = ST_FULL;
         end else begin
            // eight devices fill the 3-bit field, so no device reduction
            tbl_valid[slot] = 1'b1;
            tbl_lba[slot]   = lba;
            tbl_tag[slot]   = tag;
            tbl_dev[slot]   = dev;
            tbl_rank[slot]  = tbl_count;
            tbl_count++;
            r.status = ST_INSERTED;
         end
      end else begin
         pick = -1;
         pick_dist = '0;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (tbl_valid[i]) begin
               // full-width distance, no wrap around the lba space
               seek_gap = (tbl_head > tbl_lba[i]) ? tbl_head - tbl_lba[i]
                                                  : tbl_lba[i] - tbl_head;
               if (pick < 0 || seek_gap < pick_dist ||
                   (seek_gap == pick_dist && tbl_rank[i] < tbl_rank[pick])) begin
                  pick = i;
                  pick_dist = seek_gap;
               end
            end
         end
         if (pick < 0) begin
            r.status = ST_EMPTY;
         end else begin
            tbl_valid[pick] = 1'b0;
            // younger entries close the gap in arrival order
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (tbl_valid[i] && tbl_rank[i] > tbl_rank[pick]) tbl_rank[i]--;
            end
            tbl_count--;
            tbl_head = tbl_lba[pick];
            r.status = ST_DISPATCHED;
            r.tag    = tbl_tag[pick];
            r.lba    = tbl_lba[pick];
            r.dev    = tbl_dev[pick];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // offer one transaction after an idle gap and return once it is taken and busy is low
   task automatic send_cmd(input logic op, input logic [LBA_BITS-1:0] lba,
                           input logic [TAG_BITS-1:0] tag, input logic [DEV_BITS-1:0] dev,
                           input logic known, input rsp_fields_type want, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_opcode  <= op;
      req_lba     <= lba;
      req_tag     <= tag;
      req_device  <= dev;
      typed_known <= known;
      typed_rsp   <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold the request line low until every outstanding response is back
   task automatic wait_idle();
      start <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_lba[i]   = '0;
         tbl_tag[i]   = '0;
         tbl_dev[i]   = '0;
         tbl_rank[i]  = 0;
      end
   end

   // response checker and transaction tap; both sample pre-edge values
   always @(posedge clock) begin : rsp_check
      rsp_fields_type due;
      rsp_fields_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (rsp_due_q.size() == 0) begin
               report_mismatch("response with nothing outstanding", 64'(rsp_status), 64'd0);
            end else begin
               due = rsp_due_q.pop_front();
               if (rsp_status !== due.status)
                  report_mismatch("status", 64'(rsp_status), 64'(due.status));
               if (rsp_out_tag !== due.tag)
                  report_mismatch("tag", 64'(rsp_out_tag), 64'(due.tag));
               if (rsp_out_lba !== due.lba)
                  report_mismatch("lba", 64'(rsp_out_lba), 64'(due.lba));
               if (rsp_out_device !== due.dev)
                  report_mismatch("device", 64'(rsp_out_device), 64'(due.dev));
            end
         end
         // accepted transaction: scheduler always advances, typed rows win
         if (start && !busy) begin
            predicted = apply_request(req_opcode, req_lba, req_tag, req_device);
            rsp_due_q.push_back(typed_known ? typed_rsp : predicted);
         end
      end
   end

   initial begin : stimulus
      cmd_row_type         row;
      int                  sent;
      int                  burst_len;
      int                  ins_pct;
      bit                  idle_on;
      logic                op;
      logic [LBA_BITS-1:0] lba;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      idle_on = 1'b0;
      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         if (r % 5 == 0) idle_on = 1'($urandom_range(0, 1));
         for (int k = 0; k < row.reps; k++) begin
            send_cmd(row.op, row.lba + LBA_BITS'(k * 7), row.tag + TAG_BITS'(k),
                     row.dev + DEV_BITS'(k), row.known, row.want,
                     idle_on ? $urandom_range(0, 19) : 0);
         end
      end
      wait_idle();

      // random bursts, each with its own insert mix so the table swings
      // between empty and full; lba drawn to hit ties and both extremes
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(20, 60);
         case ($urandom_range(0, 4))
            0:       ins_pct = 10;
            1:       ins_pct = 35;
            2:       ins_pct = 50;
            3:       ins_pct = 65;
            default: ins_pct = 90;
         endcase
         idle_on = ($urandom_range(0, 2) != 0);
         for (int b = 0; b < burst_len; b++) begin
            op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DISPATCH;
            case ($urandom_range(0, 5))
               0:       lba = LBA_BITS'({$urandom, $urandom});
               1:       lba = LBA_BITS'($urandom_range(0, 31));
               2:       lba = tbl_head + LBA_BITS'($urandom_range(0, 16)) - LBA_BITS'(8);
               3:       lba = LBA_MAX - LBA_BITS'($urandom_range(0, 31));
               4:       lba = LBA_BITS'(1000 + $urandom_range(0, 63));
               default: lba = LBA_BITS'({$urandom, $urandom});
            endcase
            send_cmd(op, lba, TAG_BITS'($urandom), DEV_BITS'($urandom), 1'b0, FROM_MODEL,
                     idle_on ? $urandom_range(0, 19) : 0);
            sent++;
         end
         // now and then let everything settle before the next burst
         if ($urandom_range(0, 3) == 0) wait_idle();
      end
      start <= 1'b0;

      for (int w = 0; w < 4000 && rsp_due_q.size() != 0; w++) @(posedge clock);
      if (rsp_due_q.size() != 0)
         report_mismatch("responses never seen", 64'(rsp_due_q.size()), 64'd0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #8000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
